/* design/adts_pkg.sv */
// Shared types, constants and the sample-rate table for the ADTS deframer.
package adts_pkg;

    localparam int TsBitsDefault = 48;
    localparam int TsOutBits     = 48;
    localparam int CmdDepth      = 4;
    localparam int HdrBytes      = 7;

    localparam logic [7:0]  SyncByte      = 8'hFF;
    localparam logic [7:0]  SyncNibble    = 8'hF0;
    localparam logic [7:0]  LayerMask     = 8'h06;
    localparam logic [1:0]  ProfileSsr    = 2'd2;
    localparam logic [2:0]  LastHdrIdx    = 3'd6;
    localparam logic [12:0] MinFrameLen   = 13'd7;
    localparam logic [12:0] SamplesBlk    = 13'd1024;
    localparam logic [12:0] SamplesBlkSsr = 13'd910;

    typedef struct packed {
        logic        is_mpeg2;
        logic [1:0]  audio_profile;
        logic [16:0] rate_hz;
        logic [2:0]  channel_config;
        logic [12:0] frame_length;
        logic [2:0]  block_count;
    } t_fields;

    // one request from the parser to the emitter: a whole header or one payload byte
    typedef struct packed {
        logic                       is_hdr;
        logic                       frame_end;
        logic [HdrBytes-1:0][7:0]   bytes;
        t_fields                    fields;
    } t_cmd;

    function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
        logic [16:0] rate;
        case (idx)
            4'd0:    rate = 17'd96000;
            4'd1:    rate = 17'd88200;
            4'd2:    rate = 17'd64000;
            4'd3:    rate = 17'd48000;
            4'd4:    rate = 17'd44100;
            4'd5:    rate = 17'd32000;
            4'd6:    rate = 17'd24000;
            4'd7:    rate = 17'd22050;
            4'd8:    rate = 17'd16000;
            4'd9:    rate = 17'd12000;
            4'd10:   rate = 17'd11025;
            4'd11:   rate = 17'd8000;
            4'd12:   rate = 17'd7350;
            default: rate = 17'd0;
        endcase
        return rate;
    endfunction

endpackage

/* design/adts_front.sv */
// Sync search, header collection and decode; turns input bytes into requests.
module adts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  logic [7:0]    i_byte,
    output logic          o_cmd_push,
    output adts_pkg::t_cmd o_cmd
);
    import adts_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [12:0] r_rem, n_rem;
    logic [7:0]  r_hdr [HdrBytes];
    logic        w_acc;
    logic        w_wr;
    logic [12:0] w_flen;
    logic [7:0]  w_h2, w_h3;

    assign w_acc  = i_push && !i_full;
    assign w_h2   = r_hdr[2];
    assign w_h3   = r_hdr[3];
    assign w_flen = {w_h3[1:0], r_hdr[4], r_hdr[5][7:5]};

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_rem      = r_rem;
        w_wr       = 1'b0;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        for (int k = 0; k < HdrBytes - 1; k++) begin
            o_cmd.bytes[k] = r_hdr[k];
        end
        o_cmd.bytes[HdrBytes-1]        = i_byte;
        o_cmd.is_hdr                   = 1'b1;
        o_cmd.frame_end                = (w_flen == MinFrameLen);
        o_cmd.fields.is_mpeg2          = r_hdr[1][3];
        o_cmd.fields.audio_profile     = w_h2[7:6];
        o_cmd.fields.rate_hz           = rate_lookup(w_h2[5:2]);
        o_cmd.fields.channel_config    = {w_h2[0], w_h3[7:6]};
        o_cmd.fields.frame_length      = w_flen;
        o_cmd.fields.block_count       = {1'b0, i_byte[1:0]} + 3'd1;
        if (w_acc) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    o_cmd_push      = 1'b1;
                    o_cmd.is_hdr    = 1'b0;
                    o_cmd.frame_end = (r_rem <= 13'd1);
                    o_cmd.fields    = '0;
                    o_cmd.bytes     = '0;
                    o_cmd.bytes[0]  = i_byte;
                    if (r_rem <= 13'd1) begin
                        n_phase = PH_SEARCH;
                        n_rem   = '0;
                        n_idx   = '0;
                    end else begin
                        n_rem = r_rem - 13'd1;
                    end
                end
                PH_HEADER: begin
                    if (r_idx == 3'd0 || r_idx == 3'd7) begin
                        n_idx   = '0;
                        n_phase = PH_SEARCH;
                    end else if (r_idx == 3'd1 && (((i_byte & SyncNibble) != SyncNibble)
                                 || ((i_byte & LayerMask) != 8'd0))) begin
                        if (i_byte == SyncByte) begin
                            w_wr = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_phase = PH_SEARCH;
                        end
                    end else begin
                        w_wr  = 1'b1;
                        n_idx = r_idx + 3'd1;
                        if (r_idx == LastHdrIdx) begin
                            n_idx = '0;
                            if (w_flen < MinFrameLen) begin
                                n_phase = PH_SEARCH;
                            end else begin
                                o_cmd_push = 1'b1;
                                if (w_flen == MinFrameLen) begin
                                    n_phase = PH_SEARCH;
                                end else begin
                                    n_rem   = w_flen - MinFrameLen;
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_SEARCH;
                    if (i_byte == SyncByte) begin
                        w_wr    = 1'b1;
                        n_idx   = 3'd1;
                        n_phase = PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_idx   <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
            // a repeated sync byte at index 1 restarts the header: it lands in slot 0 and r_idx stays 1
            if (w_wr) begin
                if (r_phase == PH_HEADER && r_idx != 3'd1) begin
                    r_hdr[r_idx] <= i_byte;
                end else if (r_phase == PH_HEADER && n_idx == 3'd2) begin
                    r_hdr[1] <= i_byte;
                end else begin
                    r_hdr[0] <= i_byte;
                end
            end
        end
    end

endmodule

/* design/adts_cmd_fifo.sv */
// Short request queue between the parser and the emitter.
module adts_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  adts_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_head_vld,
    output adts_pkg::t_cmd o_head,
    input  logic           i_pop
);
    import adts_pkg::*;

    localparam int PtrW = $clog2(CmdDepth);
    localparam int CntW = $clog2(CmdDepth + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(CmdDepth);

    t_cmd            r_mem [CmdDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            w_do_push, w_do_pop;

    assign o_full     = (r_cnt == CntMax);
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_mem[r_wr] <= i_cmd;
                r_wr        <= (r_wr == PtrW'(CmdDepth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PtrW'(CmdDepth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(w_do_push) - CntW'(w_do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("request pushed into full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntMax)
        else $error("queue count beyond depth");

endmodule

/* design/adts_back.sv */
// Emitter: expands requests into result bytes and keeps the running timestamp.
module adts_back #(
    parameter int TIMESTAMP_BITS = adts_pkg::TsBitsDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head_vld,
    input  adts_pkg::t_cmd                 i_head,
    output logic                           o_head_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [7:0]                     o_byte,
    output logic                           o_start,
    output logic                           o_end,
    output logic                           o_last,
    output adts_pkg::t_fields              o_fields,
    output logic [adts_pkg::TsOutBits-1:0] o_ts
);
    import adts_pkg::*;

    logic                           r_out_vld;
    logic [2:0]                     r_k, n_k;
    logic [TIMESTAMP_BITS-1:0]      r_ts;
    t_fields                        r_fields, r_out_fields;
    logic [7:0]                     r_out_byte;
    logic                           r_start, r_end, r_last;
    logic [TsOutBits-1:0]           r_out_ts;
    logic [TsOutBits+TIMESTAMP_BITS-1:0] w_ts_wide;
    logic                           w_load, w_deq, w_start, w_end, w_last;
    logic [7:0]                     w_byte;
    t_fields                        w_fields;
    logic [12:0]                    w_per, w_addend;

    assign w_load    = i_head_vld && (!r_out_vld || i_pop);
    assign w_ts_wide = {{TsOutBits{1'b0}}, r_ts};
    assign w_fields  = i_head.is_hdr ? i_head.fields : r_fields;
    assign w_per     = (w_fields.audio_profile == ProfileSsr) ? SamplesBlkSsr : SamplesBlk;
    assign w_addend  = 13'(w_per * {10'd0, w_fields.block_count});

    always_comb begin
        if (i_head.is_hdr) begin
            w_byte  = i_head.bytes[r_k];
            w_start = (r_k == 3'd0);
            w_last  = (r_k == LastHdrIdx);
            w_end   = w_last && i_head.frame_end;
            w_deq   = w_last;
            n_k     = w_last ? 3'd0 : r_k + 3'd1;
        end else begin
            w_byte  = i_head.bytes[0];
            w_start = 1'b0;
            w_last  = 1'b1;
            w_end   = i_head.frame_end;
            w_deq   = 1'b1;
            n_k     = r_k;
        end
    end

    assign o_head_pop = w_load && w_deq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_k       <= '0;
            r_ts      <= '0;
            r_fields  <= '0;
        end else begin
            if (w_load) begin
                r_out_vld    <= 1'b1;
                r_out_byte   <= w_byte;
                r_start      <= w_start;
                r_end        <= w_end;
                r_last       <= w_last;
                r_out_fields <= w_fields;
                r_out_ts     <= w_ts_wide[TsOutBits-1:0];
                r_k          <= n_k;
                if (w_end) begin
                    r_ts <= r_ts + TIMESTAMP_BITS'(w_addend);
                end
                if (w_deq && i_head.is_hdr) begin
                    r_fields <= i_head.fields;
                end
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_empty  = !r_out_vld;
    assign o_byte   = r_out_byte;
    assign o_start  = r_start;
    assign o_end    = r_end;
    assign o_last   = r_last;
    assign o_fields = r_out_fields;
    assign o_ts     = r_out_ts;

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= LastHdrIdx)
        else $error("header byte index out of range");

    a_burst_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != 3'd0) |-> (i_head_vld && i_head.is_hdr))
        else $error("header request left mid-burst");

    a_ts_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_end) |=> (r_ts != $past(r_ts)))
        else $error("timestamp did not advance at frame end");

endmodule

/* design/adts_frame_deframer.sv */
// ADTS deframer top level: byte in, frame bytes with decoded header fields out.
// A payload byte passes through the request queue and the output register to the result ports.
// A header is emitted as seven results, one per cycle while pop keeps taking them, after its seventh byte.
// Throughput: one byte per cycle while full is low; during a header burst the 4-entry request queue
// absorbs payload bytes, then full holds off input until the burst drains.
// Reset (synchronous, active low) returns to sync search with timestamp zero.
module adts_frame_deframer #(
    parameter int TIMESTAMP_BITS = adts_pkg::TsBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_stream_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic        o_run_last,
    output logic        o_is_mpeg2,
    output logic [1:0]  o_audio_profile,
    output logic [16:0] o_rate_hz,
    output logic [2:0]  o_channel_config,
    output logic [12:0] o_frame_length,
    output logic [2:0]  o_block_count,
    output logic [adts_pkg::TsOutBits-1:0] o_frame_timestamp
);
    import adts_pkg::*;

    logic    w_cmd_push, w_head_vld, w_head_pop;
    t_cmd    w_cmd, w_head;
    t_fields w_fields;

    adts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_byte     (i_stream_byte),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd)
    );

    adts_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_cmd_push),
        .i_cmd      (w_cmd),
        .o_full     (full),
        .o_head_vld (w_head_vld),
        .o_head     (w_head),
        .i_pop      (w_head_pop)
    );

    adts_back #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (w_head_vld),
        .i_head     (w_head),
        .o_head_pop (w_head_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_byte     (o_frame_byte),
        .o_start    (o_frame_start),
        .o_end      (o_frame_end),
        .o_last     (o_run_last),
        .o_fields   (w_fields),
        .o_ts       (o_frame_timestamp)
    );

    assign o_is_mpeg2       = w_fields.is_mpeg2;
    assign o_audio_profile  = w_fields.audio_profile;
    assign o_rate_hz        = w_fields.rate_hz;
    assign o_channel_config = w_fields.channel_config;
    assign o_frame_length   = w_fields.frame_length;
    assign o_block_count    = w_fields.block_count;

endmodule

/* tb/sv/tb_adts_frame_deframer.sv */
// Self-checking testbench for adts_frame_deframer: byte-stream stimulus, result prediction and compare.
`timescale 1ns / 1ps

module tb_adts_frame_deframer;
    import adts_pkg::*;

    localparam int CycleLimit   = 500000;
    localparam int RandomBytes  = 360;

    typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_BODY} t_phase;

    typedef struct packed {
        logic [7:0]           data;
        logic                 sof;
        logic                 eof;
        logic                 run_last;
        t_fields              fields;
        logic [TsOutBits-1:0] stamp;
    } t_frame_result;

    class deframe_tracker;
        t_frame_result        pending_bytes[$];
        t_phase               phase = PH_HUNT;
        logic [7:0]           hdr[HdrBytes];
        int                   idx = 0;
        logic [12:0]          remaining = '0;
        logic [TsOutBits-1:0] running_samples = '0;
        t_fields              cur = '0;
        int                   errors = 0;
        int                   bytes_in = 0;
        int                   results = 0;
        int                   frames = 0;
        int                   short_frames = 0;
        int                   lost_syncs = 0;
        logic [16:0]          rate_tab[16] = '{
            17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
            17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
            17'd7350, 17'd0, 17'd0, 17'd0};

        function void queue_result(logic [7:0] b, logic sof, logic eof, logic run_last);
            t_frame_result r;
            r.data     = b;
            r.sof      = sof;
            r.eof      = eof;
            r.run_last = run_last;
            r.fields   = cur;
            r.stamp    = running_samples;
            pending_bytes.push_back(r);
        endfunction

        function void close_frame();
            logic [12:0] per_block;
            per_block = (cur.audio_profile == ProfileSsr) ? SamplesBlkSsr : SamplesBlk;
            running_samples = running_samples
                              + TsOutBits'(per_block) * TsOutBits'(cur.block_count);
            remaining = '0;
            idx = 0;
            phase = PH_HUNT;
        endfunction

        function void decode_header();
            logic [12:0] flen;
            flen = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
            idx = 0;
            if (flen < MinFrameLen) begin
                phase = PH_HUNT;
                short_frames++;
                return;
            end
            cur.is_mpeg2       = hdr[1][3];
            cur.audio_profile  = hdr[2][7:6];
            cur.rate_hz        = rate_tab[hdr[2][5:2]];
            cur.channel_config = {hdr[2][0], hdr[3][7:6]};
            cur.frame_length   = flen;
            cur.block_count    = {1'b0, hdr[6][1:0]} + 3'd1;
            for (int k = 0; k < HdrBytes; k++)
                queue_result(hdr[k], k == 0, (k == HdrBytes - 1) && (flen == MinFrameLen),
                             k == HdrBytes - 1);
            if (flen == MinFrameLen)
                close_frame();
            else begin
                remaining = flen - MinFrameLen;
                phase = PH_BODY;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            bytes_in++;
            case (phase)
                PH_BODY: begin
                    queue_result(b, 1'b0, remaining <= 13'd1, 1'b1);
                    if (remaining <= 13'd1)
                        close_frame();
                    else
                        remaining = remaining - 13'd1;
                end
                PH_HEADER: begin
                    if (idx == 1 && (((b & SyncNibble) != SyncNibble) || ((b & LayerMask) != 0))) begin
                        lost_syncs++;
                        if (b == SyncByte) begin
                            hdr[0] = b;
                            idx = 1;
                        end else begin
                            idx = 0;
                            phase = PH_HUNT;
                        end
                    end else begin
                        hdr[idx] = b;
                        idx++;
                        if (idx == HdrBytes)
                            decode_header();
                    end
                end
                default: begin
                    if (b == SyncByte) begin
                        hdr[0] = b;
                        idx = 1;
                        phase = PH_HEADER;
                    end
                end
            endcase
        endfunction

        function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void match_output(t_frame_result got);
            t_frame_result exp;
            if (pending_bytes.size() == 0) begin
                $error("result with nothing pending: frame_byte %0h", got.data);
                errors++;
                return;
            end
            exp = pending_bytes.pop_front();
            results++;
            if (exp.sof)
                frames++;
            cmp_field("frame_byte", 64'(exp.data), 64'(got.data));
            cmp_field("frame_start", 64'(exp.sof), 64'(got.sof));
            cmp_field("frame_end", 64'(exp.eof), 64'(got.eof));
            cmp_field("run_last", 64'(exp.run_last), 64'(got.run_last));
            cmp_field("is_mpeg2", 64'(exp.fields.is_mpeg2), 64'(got.fields.is_mpeg2));
            cmp_field("audio_profile", 64'(exp.fields.audio_profile),
                      64'(got.fields.audio_profile));
            cmp_field("rate_hz", 64'(exp.fields.rate_hz), 64'(got.fields.rate_hz));
            cmp_field("channel_config", 64'(exp.fields.channel_config),
                      64'(got.fields.channel_config));
            cmp_field("frame_length", 64'(exp.fields.frame_length),
                      64'(got.fields.frame_length));
            cmp_field("block_count", 64'(exp.fields.block_count),
                      64'(got.fields.block_count));
            cmp_field("frame_timestamp", 64'(exp.stamp), 64'(got.stamp));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_stream_byte = '0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_frame_byte;
    logic        o_frame_start;
    logic        o_frame_end;
    logic        o_run_last;
    logic        o_is_mpeg2;
    logic [1:0]  o_audio_profile;
    logic [16:0] o_rate_hz;
    logic [2:0]  o_channel_config;
    logic [12:0] o_frame_length;
    logic [2:0]  o_block_count;
    logic [TsOutBits-1:0] o_frame_timestamp;

    deframe_tracker sb = new();
    int             cycle_cnt = 0;
    int             burst_left = 0;
    bit             steady = 1'b0;
    int             rx_tick = 0;
    int             rx_mode = 0;

    adts_frame_deframer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_stream_byte     (i_stream_byte),
        .empty             (empty),
        .pop               (pop),
        .o_frame_byte      (o_frame_byte),
        .o_frame_start     (o_frame_start),
        .o_frame_end       (o_frame_end),
        .o_run_last        (o_run_last),
        .o_is_mpeg2        (o_is_mpeg2),
        .o_audio_profile   (o_audio_profile),
        .o_rate_hz         (o_rate_hz),
        .o_channel_config  (o_channel_config),
        .o_frame_length    (o_frame_length),
        .o_block_count     (o_block_count),
        .o_frame_timestamp (o_frame_timestamp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CycleLimit);
        $display("FAIL adts_frame_deframer");
        $finish;
    end

    // receiver: switches between free-running, random, periodic and long-stall pop patterns
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 256 == 255)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= (rx_tick % 7) < 4;
            default: pop <= (rx_tick % 40) >= 25;
        endcase
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n) begin
            if (push && !full)
                sb.take_byte(i_stream_byte);
            if (pop && !empty) begin
                got.data     = o_frame_byte;
                got.sof      = o_frame_start;
                got.eof      = o_frame_end;
                got.run_last = o_run_last;
                got.fields.is_mpeg2       = o_is_mpeg2;
                got.fields.audio_profile  = o_audio_profile;
                got.fields.rate_hz        = o_rate_hz;
                got.fields.channel_config = o_channel_config;
                got.fields.frame_length   = o_frame_length;
                got.fields.block_count    = o_block_count;
                got.stamp    = o_frame_timestamp;
                sb.match_output(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic id, input logic [1:0] prof, input logic [3:0] sr,
                              input logic [2:0] ch, input logic [12:0] flen,
                              input logic [1:0] rdb, input logic [31:0] fill);
        logic [7:0] hdr[HdrBytes];
        int         n_pay;
        hdr[0] = SyncByte;
        hdr[1] = {4'hF, id, 2'b00, fill[0]};
        hdr[2] = {prof, sr, fill[1], ch[2]};
        hdr[3] = {ch[1:0], fill[5:2], flen[12:11]};
        hdr[4] = flen[10:3];
        hdr[5] = {flen[2:0], fill[10:6]};
        hdr[6] = {fill[16:11], rdb};
        for (int k = 0; k < HdrBytes; k++)
            send_byte(hdr[k]);
        n_pay = (flen >= MinFrameLen) ? int'(flen - MinFrameLen) : 0;
        repeat (n_pay) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frame(input logic [12:0] flen);
        send_frame(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), flen,
                   2'($urandom_range(0, 3)), $urandom());
    endtask

    initial begin
        int          counted;
        int          pick;
        int          r;
        logic [12:0] flen;
        logic [7:0]  bad;
        counted = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle byte, lost syncs, repeated sync, header-only, short and minimal frames
        send_byte(8'h00);
        send_byte(SyncByte);
        send_byte(8'h00);
        send_byte(SyncByte);
        send_byte(8'hF2);
        send_byte(SyncByte);
        send_frame(1'b1, ProfileSsr, 4'd15, 3'd7, MinFrameLen, 2'd3, '1);
        send_frame(1'b0, 2'd1, 4'd12, 3'd0, 13'd0, 2'd0, '0);
        send_frame(1'b0, 2'd0, 4'd0, 3'd0, 13'd8, 2'd0, '0);

        while (counted < RandomBytes) begin
            if ($urandom_range(0, 15) == 0)
                steady = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                r = $urandom_range(0, 19);
                if (r < 18)
                    flen = 13'($urandom_range(7, 12));
                else if (r == 18)
                    flen = 13'($urandom_range(13, 40));
                else
                    flen = 13'($urandom_range(41, 160));
                send_random_frame(flen);
                counted += int'(flen);
            end else if (pick < 83) begin
                send_random_frame(13'($urandom_range(0, 6)));
                counted += HdrBytes;
            end else if (pick < 92) begin
                do bad = 8'($urandom_range(0, 255));
                while (((bad & SyncNibble) == SyncNibble) && ((bad & LayerMask) == 0));
                send_byte(SyncByte);
                send_byte(bad);
                counted += 2;
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
            end
        end

        push <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.pending_bytes.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_bytes.size());
            sb.errors++;
        end
        $display("Run: %0d stream bytes in, %0d results checked, %0d frames emitted,",
                 sb.bytes_in, sb.results, sb.frames);
        $display("     %0d short headers dropped, %0d sync candidates lost.",
                 sb.short_frames, sb.lost_syncs);
        if (sb.errors == 0)
            $display("PASS adts_frame_deframer");
        else
            $display("FAIL adts_frame_deframer");
        $finish;
    end

endmodule
